// ===== rtl/snrs_pkg.sv =====
// Shared types and constants for the SPI NOR request splitter.
// Used by the front classifier, the request queue, the walker and the top level.
`default_nettype none

package snrs_pkg;

  localparam int ADDR_W = 26;
  localparam int CAP_W  = 27;
  localparam int LEN_W  = 16;
  localparam int FADDR_W = 24;
  localparam int CMD_W  = 8;
  localparam int ERR_W  = 2;
  localparam int OP_W   = 2;

  // Flash geometry and request limits (powers of two for page and sector).
  localparam int PAGE_BYTES    = 256;
  localparam int SECTOR_BYTES  = 4096;
  localparam int MAX_REQ_BYTES = 8192;
  localparam int MAX_RES       = 33;

  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int NEED_W       = LEN_W + 1;
  localparam int ROOM_W       = PAGE_SHIFT + 1;

  // Request queue between front and walker.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_PART_PRESENT = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY     = REG_IDX_W'(1);

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_PROG  = 2'd1;
  localparam logic [OP_W-1:0] OP_ERASE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  localparam logic [CMD_W-1:0] CMD_NONE  = 8'h00;
  localparam logic [CMD_W-1:0] CMD_READ  = 8'h03;
  localparam logic [CMD_W-1:0] CMD_PROG  = 8'h02;
  localparam logic [CMD_W-1:0] CMD_ERASE = 8'h20;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ABSENT   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LENGTH   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_CAPACITY = 2'd3;

  typedef enum logic [1:0] {
    KIND_ERR,
    KIND_READ,
    KIND_PROG,
    KIND_ERASE
  } kind_t;

  // Classified request handed from front to walker.
  typedef struct packed {
    kind_t               kind;
    logic [ERR_W-1:0]    err;
    logic [CAP_W-1:0]    first;
    logic [CAP_W-1:0]    stop;
    logic [LEN_W-1:0]    len;
  } desc_t;

endpackage

`default_nettype wire

// ===== rtl/snrs_front.sv =====
// Front classifier: checks a request against the configuration and turns it
// into a descriptor for the queue. Depends on snrs_pkg.
`default_nettype none

module snrs_front (
  input  wire logic                          in_valid,
  input  wire logic [snrs_pkg::OP_W-1:0]     opcode,
  input  wire logic [snrs_pkg::ADDR_W-1:0]   address,
  input  wire logic [snrs_pkg::LEN_W-1:0]    length,
  input  wire logic                          part_present,
  input  wire logic [snrs_pkg::CAP_W-1:0]    capacity,
  input  wire logic                          q_full,
  output logic                               push,
  output snrs_pkg::desc_t                    desc
);

  localparam int SS = snrs_pkg::SECTOR_SHIFT;
  localparam int PS = snrs_pkg::PAGE_SHIFT;
  localparam int CW = snrs_pkg::CAP_W;
  localparam int NW = snrs_pkg::NEED_W;

  logic [CW-1:0]    lin_stop;
  logic [CW-1:0]    ers_sum;
  logic [CW-1:0]    ers_first;
  logic [CW-1:0]    ers_stop;
  logic [CW-SS-1:0] ers_need;
  logic [NW-1:0]    prg_sum;
  logic [NW-1:0]    need;
  logic [CW-1:0]    stop;
  logic             bad_len;

  always_comb begin
    lin_stop  = CW'(address) + CW'(length);
    ers_sum   = CW'(address) + CW'(length) + CW'(snrs_pkg::SECTOR_BYTES - 1);
    ers_stop  = {ers_sum[CW-1:SS], SS'(0)};
    ers_first = {1'b0, address[snrs_pkg::ADDR_W-1:SS], SS'(0)};
    ers_need  = ers_sum[CW-1:SS] - ers_first[CW-1:SS];
    prg_sum   = NW'(address[PS-1:0]) + NW'(length) + NW'(snrs_pkg::PAGE_BYTES - 1);
    bad_len   = (length == '0) ||
                (length > snrs_pkg::LEN_W'(snrs_pkg::MAX_REQ_BYTES));

    unique case (opcode)
      snrs_pkg::OP_PROG: begin
        need = prg_sum >> PS;
        stop = lin_stop;
      end
      snrs_pkg::OP_ERASE: begin
        need = NW'(ers_need);
        stop = ers_stop;
      end
      default: begin
        need = NW'(1);
        stop = lin_stop;
      end
    endcase

    desc.first = (opcode == snrs_pkg::OP_ERASE) ? ers_first : CW'(address);
    desc.stop  = stop;
    desc.len   = length;
    desc.err   = snrs_pkg::ERR_NONE;
    desc.kind  = snrs_pkg::KIND_ERR;

    // Error priority: absent part, bad length, too many transactions, capacity.
    priority if (!part_present) begin
      desc.err = snrs_pkg::ERR_ABSENT;
    end else if (bad_len || (need > NW'(snrs_pkg::MAX_RES))) begin
      desc.err = snrs_pkg::ERR_LENGTH;
    end else if (stop > capacity) begin
      desc.err = snrs_pkg::ERR_CAPACITY;
    end else begin
      unique case (opcode)
        snrs_pkg::OP_PROG:  desc.kind = snrs_pkg::KIND_PROG;
        snrs_pkg::OP_ERASE: desc.kind = snrs_pkg::KIND_ERASE;
        default:            desc.kind = snrs_pkg::KIND_READ;
      endcase
    end
  end

  // Drop the unused opcode without queuing anything.
  assign push = in_valid && !q_full && (opcode != snrs_pkg::OP_NONE);

endmodule

`default_nettype wire

// ===== rtl/snrs_queue.sv =====
// Short descriptor queue between the front classifier and the walker.
// Depends on snrs_pkg for the descriptor type and depth.
`default_nettype none

module snrs_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire snrs_pkg::desc_t push_desc,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output snrs_pkg::desc_t      head
);

  localparam int PW = snrs_pkg::QPTR_W;
  localparam int CNW = snrs_pkg::QCNT_W;

  snrs_pkg::desc_t  mem_r [snrs_pkg::QDEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNW-1:0]   count_r, count_nxt;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(snrs_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  assign full      = (count_r == CNW'(snrs_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNW'(push) - CNW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/snrs_walker.sv =====
// Walker: takes one descriptor at a time from the queue and emits its flash
// transactions, one per cycle unless stalled, into the output register. Depends on snrs_pkg.
`default_nettype none

module snrs_walker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_not_empty,
  input  wire snrs_pkg::desc_t                   q_head,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [snrs_pkg::CMD_W-1:0]             out_command,
  output logic [snrs_pkg::FADDR_W-1:0]           out_flash_address,
  output logic [snrs_pkg::LEN_W-1:0]             out_byte_count,
  output logic                                   out_write_enable_first,
  output logic                                   out_poll_until_idle,
  output logic [snrs_pkg::ERR_W-1:0]             out_error,
  output logic                                   out_last
);

  localparam int CW = snrs_pkg::CAP_W;
  localparam int LW = snrs_pkg::LEN_W;
  localparam int PS = snrs_pkg::PAGE_SHIFT;
  localparam int RW = snrs_pkg::ROOM_W;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                      state_r;
  snrs_pkg::kind_t             kind_r;
  logic [snrs_pkg::ERR_W-1:0]  err_r;
  logic [CW-1:0]               cur_r, cur_nxt;
  logic [CW-1:0]               stop_r;
  logic [LW-1:0]               left_r, left_nxt;
  logic                        out_valid_r;
  logic [snrs_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [snrs_pkg::FADDR_W-1:0] faddr_r;
  logic [LW-1:0]               count_r, count_nxt;
  logic                        flags_r, flags_nxt;
  logic [snrs_pkg::ERR_W-1:0]  oerr_r, oerr_nxt;
  logic                        last_r, last_nxt;

  logic                        slot_free;
  logic                        emit;
  logic [RW-1:0]               room;
  logic                        fits;
  logic [LW-1:0]               chunk;
  logic [CW-1:0]               ers_next;

  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = (state_r == ST_RUN) && slot_free;
  assign q_pop     = (state_r == ST_IDLE) && q_not_empty;

  always_comb begin
    room     = RW'(snrs_pkg::PAGE_BYTES) - RW'(cur_r[PS-1:0]);
    fits     = left_r <= LW'(room);
    chunk    = fits ? left_r : LW'(room);
    ers_next = cur_r + CW'(snrs_pkg::SECTOR_BYTES);

    cur_nxt   = cur_r;
    left_nxt  = left_r;
    cmd_nxt   = snrs_pkg::CMD_NONE;
    count_nxt = '0;
    flags_nxt = 1'b0;
    oerr_nxt  = snrs_pkg::ERR_NONE;
    last_nxt  = 1'b1;

    unique case (kind_r)
      snrs_pkg::KIND_ERR: begin
        oerr_nxt = err_r;
      end
      snrs_pkg::KIND_READ: begin
        cmd_nxt   = snrs_pkg::CMD_READ;
        count_nxt = left_r;
      end
      snrs_pkg::KIND_PROG: begin
        cmd_nxt   = snrs_pkg::CMD_PROG;
        count_nxt = chunk;
        flags_nxt = 1'b1;
        last_nxt  = fits;
        cur_nxt   = cur_r + CW'(chunk);
        left_nxt  = left_r - chunk;
      end
      snrs_pkg::KIND_ERASE: begin
        cmd_nxt   = snrs_pkg::CMD_ERASE;
        flags_nxt = 1'b1;
        last_nxt  = ers_next >= stop_r;
        cur_nxt   = ers_next;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_not_empty) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (emit && last_nxt) begin
            state_r <= ST_IDLE;
          end
        end
      endcase
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk registers and output payload need no reset.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_head.kind;
      err_r  <= q_head.err;
      cur_r  <= q_head.first;
      stop_r <= q_head.stop;
      left_r <= q_head.len;
    end else if (emit) begin
      cur_r  <= cur_nxt;
      left_r <= left_nxt;
    end
    if (emit) begin
      cmd_r   <= cmd_nxt;
      faddr_r <= (kind_r == snrs_pkg::KIND_ERR) ? '0 : cur_r[snrs_pkg::FADDR_W-1:0];
      count_r <= count_nxt;
      flags_r <= flags_nxt;
      oerr_r  <= oerr_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_command            = cmd_r;
  assign out_flash_address      = faddr_r;
  assign out_byte_count         = count_r;
  assign out_write_enable_first = flags_r;
  assign out_poll_until_idle    = flags_r;
  assign out_error              = oerr_r;
  assign out_last               = last_r;

endmodule

`default_nettype wire

// ===== rtl/spi_nor_request_splitter_top.sv =====
// SPI NOR request splitter, top level: configuration registers, front
// classifier, request queue and walker. Depends on snrs_pkg and the snrs_* modules.
//
// Usage: a flash request (opcode, address, length) enters on the in_ channel
// when in_valid is high and in_stall low. Each request yields a run of SPI
// transactions on the out_ channel, the final one flagged by out_last; a
// rejected request yields a single result carrying the error code, and
// opcode 3 yields nothing. The APB port holds part_present (offset 0) and
// capacity_bytes (offset 4); write it only while the block is idle.
// Timing: the front classifies a request combinationally and writes it into
// the queue when it is accepted; the walker pops it from the queue when idle
// and then emits one transaction per cycle while the output is not stalled.
// A request yields up to 33 results (MAX_RES, e.g. a 33-page program), and
// the walker returns to idle before it takes the next one. Two classified
// requests can wait in the queue; in_stall rises while it is full.
// Reset clears the registers, the queue and the output valid. When out_stall
// is high a valid result holds and the walker pauses.
`default_nettype none

module spi_nor_request_splitter_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [snrs_pkg::OP_W-1:0]           in_opcode,
  input  wire logic [snrs_pkg::ADDR_W-1:0]         in_address,
  input  wire logic [snrs_pkg::LEN_W-1:0]          in_length,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [snrs_pkg::CMD_W-1:0]               out_command,
  output logic [snrs_pkg::FADDR_W-1:0]             out_flash_address,
  output logic [snrs_pkg::LEN_W-1:0]               out_byte_count,
  output logic                                     out_write_enable_first,
  output logic                                     out_poll_until_idle,
  output logic [snrs_pkg::ERR_W-1:0]               out_error,
  output logic                                     out_last,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [snrs_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [snrs_pkg::PDATA_W-1:0]        pwdata,
  output logic [snrs_pkg::PDATA_W-1:0]             prdata,
  output logic                                     pready
);

  localparam int CW = snrs_pkg::CAP_W;
  localparam int DW = snrs_pkg::PDATA_W;

  logic                               part_present_r;
  logic [CW-1:0]                      capacity_r;
  logic                               reg_wr;
  logic [snrs_pkg::REG_IDX_W-1:0]     reg_idx;

  logic                               push;
  snrs_pkg::desc_t                    push_desc;
  logic                               q_full;
  logic                               q_not_empty;
  logic                               q_pop;
  snrs_pkg::desc_t                    q_head;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[snrs_pkg::PADDR_W-1:2];
  assign prdata  = (reg_idx == snrs_pkg::REG_CAPACITY) ? DW'(capacity_r)
                                                       : DW'(part_present_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_present_r <= 1'b0;
      capacity_r     <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        snrs_pkg::REG_PART_PRESENT: part_present_r <= pwdata[0];
        snrs_pkg::REG_CAPACITY:     capacity_r     <= pwdata[CW-1:0];
      endcase
    end
  end

  assign in_stall = q_full;

  snrs_front u_front (
    .in_valid     (in_valid),
    .opcode       (in_opcode),
    .address      (in_address),
    .length       (in_length),
    .part_present (part_present_r),
    .capacity     (capacity_r),
    .q_full       (q_full),
    .push         (push),
    .desc         (push_desc)
  );

  snrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  snrs_walker u_walker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_not_empty            (q_not_empty),
    .q_head                 (q_head),
    .q_pop                  (q_pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_command            (out_command),
    .out_flash_address      (out_flash_address),
    .out_byte_count         (out_byte_count),
    .out_write_enable_first (out_write_enable_first),
    .out_poll_until_idle    (out_poll_until_idle),
    .out_error              (out_error),
    .out_last               (out_last)
  );

  localparam int SW = snrs_pkg::LEN_W + 1;
  localparam int PS = snrs_pkg::PAGE_SHIFT;

  // An error result stands alone and carries no command.
  a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error != snrs_pkg::ERR_NONE) |->
      (out_command == snrs_pkg::CMD_NONE) && out_last && !out_write_enable_first)
    else $error("error result is not a lone empty transaction");

  // A page program never crosses a page boundary and is never empty.
  a_prog_in_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command == snrs_pkg::CMD_PROG) |->
      (out_byte_count != '0) &&
      ((SW'(out_flash_address[PS-1:0]) + SW'(out_byte_count)) <=
       SW'(snrs_pkg::PAGE_BYTES)))
    else $error("program transaction crosses a page");

  // Program and erase transactions carry write enable and poll together.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_command == snrs_pkg::CMD_PROG) ||
                  (out_command == snrs_pkg::CMD_ERASE)) |->
      out_write_enable_first && out_poll_until_idle)
    else $error("program or erase without write enable and poll");

  // A write to the presence register takes effect on the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && reg_wr && (reg_idx == snrs_pkg::REG_PART_PRESENT) |=>
      (part_present_r == $past(pwdata[0])))
    else $error("presence register write lost");

endmodule

`default_nettype wire
